// ===== hw/rtl/sha1_stream_hasher_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Shared assertion macros for the hasher RTL, removed when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/sha1sh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Payload types, sequencer states, SHA-1 constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

  localparam int unsigned ROUNDS = 80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_item_t;

  typedef enum logic [2:0] {
    S_IN,
    S_PAD,
    S_PRE,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = IV0;
      3'd1:    v = IV1;
      3'd2:    v = IV2;
      3'd3:    v = IV3;
      default: v = IV4;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  // Keeps the leading valid bytes of a short final word and appends the pad byte.
  function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [2:0] nb);
    logic [31:0] r;
    case (nb)
      3'd1:    r = {w[31:24], PAD_BYTE, 16'h0000};
      3'd2:    r = {w[31:16], PAD_BYTE, 8'h00};
      3'd3:    r = {w[31:8], PAD_BYTE};
      default: r = {PAD_BYTE, 24'h000000};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Streaming SHA-1 digest over big-endian message words with built-in padding.
// ----------------------------------------------------------------------------
// Words are written into the block buffer at one per cycle while the hasher
// is taking input. The sixteenth word of a block starts a compression: one
// schedule prefetch, 80 rounds at one per cycle, and one chaining add; no new
// words are taken until it ends, so the single round unit and the registered
// reads of the schedule memories set the sustained rate. The final word is
// followed by the padding words, one or two compressions, and a hand-off of
// the digest to the output buffer; the five digest words then leave one per
// transfer while the next message is already being taken in.
`default_nettype none

`include "sha1_stream_hasher_defines.svh"

module sha1_stream_hasher
  import sha1sh_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  input  wire            msg_valid,
  output logic           msg_ready,
  input  wire msg_item_t msg_item,
  output logic           dig_valid,
  input  wire            dig_ready,
  output dig_item_t      dig_item
);

  state_t      state;
  state_t      state_next;

  logic [3:0]  wpos;
  logic [6:0]  rnd;
  logic [63:0] bitcnt;
  logic        pad_active;
  logic        pad_marker;
  logic        pad_len;
  logic        final_blk;

  logic [31:0] cv [5];
  logic [31:0] wr [5];

  logic [31:0] mem_a [16];
  logic [31:0] mem_b [16];
  logic [31:0] rd_a0;
  logic [31:0] rd_a1;
  logic [31:0] rd_b0;
  logic [31:0] rd_b1;

  logic [31:0] obuf [5];
  logic [2:0]  oidx;
  logic        obusy;

  logic        accept;
  logic [2:0]  nb;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [3:0]  tr;
  logic [31:0] pad_data;
  logic [31:0] sched_x;
  logic [31:0] w_cur;
  logic [31:0] f_val;
  logic [31:0] tmp;

  assign accept = msg_valid && msg_ready;
  assign nb = (!msg_item.end_of_message || msg_item.valid_bytes > FULL_BYTES) ?
              FULL_BYTES : msg_item.valid_bytes;

  always_comb begin
    if (pad_marker) begin
      pad_data = {PAD_BYTE, 24'h000000};
    end else if (pad_len) begin
      pad_data = bitcnt[31:0];
    end else if (wpos == 4'd14) begin
      pad_data = bitcnt[63:32];
    end else begin
      pad_data = 32'h0;
    end
  end

  assign tr      = (state == S_PRE) ? 4'd0 : rnd[3:0] + 4'd1;
  assign sched_x = rd_a0 ^ rd_a1 ^ rd_b0 ^ rd_b1;
  assign w_cur   = (rnd < 7'd16) ? rd_b1 : {sched_x[30:0], sched_x[31]};

  always_comb begin
    if (rnd < 7'd20) begin
      f_val = (wr[1] & wr[2]) | (~wr[1] & wr[3]);
    end else if (rnd < 7'd40 || rnd >= 7'd60) begin
      f_val = wr[1] ^ wr[2] ^ wr[3];
    end else begin
      f_val = (wr[1] & wr[2]) | (wr[1] & wr[3]) | (wr[2] & wr[3]);
    end
  end

  assign tmp = {wr[0][26:0], wr[0][31:27]} + f_val + wr[4] + w_cur + round_k(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IN: begin
        if (accept) begin
          if (wpos == 4'd15) begin
            state_next = S_PRE;
          end else if (msg_item.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (wpos == 4'd15) begin
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        state_next = S_ROUND;
      end
      S_ROUND: begin
        if (rnd == 7'(ROUNDS - 1)) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (final_blk) begin
          state_next = S_DONE;
        end else if (pad_active) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IN;
        end
      end
      S_DONE: begin
        if (!obusy) begin
          state_next = S_IN;
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  always_comb begin
    msg_ready = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = wpos;
    mem_wd    = msg_item.message_word;
    unique case (state)
      S_IN: begin
        msg_ready = 1'b1;
        mem_we    = accept;
        if (msg_item.end_of_message && nb != FULL_BYTES) begin
          mem_wd = pad_word(msg_item.message_word, nb);
        end
      end
      S_PAD: begin
        mem_we = 1'b1;
        mem_wd = pad_data;
      end
      S_ROUND: begin
        mem_we = (rnd >= 7'd16);
        mem_wa = rnd[3:0];
        mem_wd = w_cur;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign dig_valid            = obusy;
  assign dig_item.digest_word = obuf[0];
  assign dig_item.word_index  = oidx;
  assign dig_item.last_word   = (oidx == 3'd4);

  // Two copies of the schedule give four read ports per round.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[mem_wa] <= mem_wd;
      mem_b[mem_wa] <= mem_wd;
    end
    rd_a0 <= mem_a[tr - 4'd3];
    rd_a1 <= mem_a[tr - 4'd8];
    rd_b0 <= mem_b[tr - 4'd14];
    rd_b1 <= mem_b[tr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos       <= 4'd0;
      rnd        <= 7'd0;
      bitcnt     <= 64'd0;
      pad_active <= 1'b0;
      pad_marker <= 1'b0;
      pad_len    <= 1'b0;
      final_blk  <= 1'b0;
      obusy      <= 1'b0;
      oidx       <= 3'd0;
      for (int i = 0; i < 5; i++) begin
        cv[i] <= iv_word(3'(i));
        wr[i] <= 32'h0;
      end
    end else begin
      if (obusy && dig_ready) begin
        for (int i = 0; i < 4; i++) begin
          obuf[i] <= obuf[i + 1];
        end
        oidx <= oidx + 3'd1;
        if (oidx == 3'd4) begin
          obusy <= 1'b0;
        end
      end
      case (state)
        S_IN: begin
          if (accept) begin
            wpos   <= wpos + 4'd1;
            bitcnt <= bitcnt + {58'd0, nb, 3'b000};
            if (msg_item.end_of_message) begin
              pad_active <= 1'b1;
              pad_marker <= (nb == FULL_BYTES);
            end
          end
        end
        S_PAD: begin
          wpos <= wpos + 4'd1;
          if (pad_marker) begin
            pad_marker <= 1'b0;
          end else if (pad_len) begin
            final_blk <= 1'b1;
          end else if (wpos == 4'd14) begin
            pad_len <= 1'b1;
          end
        end
        S_PRE: begin
          rnd <= 7'd0;
          for (int i = 0; i < 5; i++) begin
            wr[i] <= cv[i];
          end
        end
        S_ROUND: begin
          wr[0] <= tmp;
          wr[1] <= wr[0];
          wr[2] <= {wr[1][1:0], wr[1][31:2]};
          wr[3] <= wr[2];
          wr[4] <= wr[3];
          rnd   <= (rnd == 7'(ROUNDS - 1)) ? 7'd0 : rnd + 7'd1;
        end
        S_ADD: begin
          for (int i = 0; i < 5; i++) begin
            cv[i] <= cv[i] + wr[i];
          end
        end
        S_DONE: begin
          if (!obusy) begin
            for (int i = 0; i < 5; i++) begin
              obuf[i] <= cv[i];
              cv[i]   <= iv_word(3'(i));
            end
            obusy      <= 1'b1;
            oidx       <= 3'd0;
            bitcnt     <= 64'd0;
            pad_active <= 1'b0;
            pad_marker <= 1'b0;
            pad_len    <= 1'b0;
            final_blk  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_pre_on_block_edge, clk, rst, state == S_PRE, wpos == 4'd0)
  `ASSERT_NEXT(a_rounds_end_in_add, clk, rst, state == S_ROUND && rnd == 7'(ROUNDS - 1),
               state == S_ADD)
  `ASSERT_IMPLY(a_len_low_at_end, clk, rst, state == S_PAD && pad_len && !pad_marker,
                wpos == 4'd15)
  `ASSERT_NEXT(a_last_word_frees_buffer, clk, rst, dig_valid && dig_ready && dig_item.last_word,
               !dig_valid)

endmodule

`default_nettype wire
